// File: rtl/tmhs_pkg.sv
// Package with the shared types, constants and codes of the timer heap scheduler.
`timescale 1ns / 1ps
package tmhs_pkg;

  localparam int HANDLE_W       = 6;
  localparam int NUM_HANDLES    = 64;
  localparam int TIME_W         = 64;
  localparam int TAG_W          = 32;
  localparam int BUDGET_W       = 7;
  localparam int COUNT_W        = 7;
  localparam int BUDGET_MAX     = 64;
  localparam int MAX_TIMERS_DEF = 64;
  localparam int IN_DATA_W      = 240;
  localparam int OUT_DATA_W     = 112;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIS_POS,
    ST_DIS_LAST,
    ST_ARM,
    ST_SD_START,
    ST_SD_L,
    ST_SD_R,
    ST_SU_START,
    ST_SU_P,
    ST_EXP_CHK,
    ST_EXP_TM,
    ST_EXP_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] h;
    logic [TIME_W-1:0]   d;
  } heap_ent_t;

endpackage

// File: rtl/tmhs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tmhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tmhs_rem_div.sv
// Restoring divider that yields the remainder of a 64-bit division, one bit per cycle.
`timescale 1ns / 1ps
module tmhs_rem_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tmhs_pkg::TIME_W-1:0] dividend,
  input  logic [tmhs_pkg::TIME_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [tmhs_pkg::TIME_W-1:0] rem
);

  localparam int W  = tmhs_pkg::TIME_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  x_r, x_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    rem_nxt  = rem_r;
    x_nxt    = x_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, x_r[W-1]};
    diff     = trial - {1'b0, d_r};
    if (start) begin
      rem_nxt  = '0;
      x_nxt    = dividend;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[W-2:0], 1'b0};
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
      end else begin
        rem_nxt = trial[W-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    x_r   <= x_nxt;
    d_r   <= d_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/timer_min_heap_scheduler_unit.sv
// Top level of the timer heap scheduler: sequencer, heap memories and output register.
`timescale 1ns / 1ps
// The block keeps up to min(MAX_TIMERS, 64) armed timers in a binary min-heap held in
// a slot memory, with a handle-to-slot memory and a timer memory beside it, each read
// through a registered read port. One transaction is taken at a time. A set or a remove
// walks the heap level by level; an expire does the same per fired timer, and each
// periodic timer's new deadline needs the remainder from a divider that retires one bit
// a cycle. Each fired timer gives one result transaction; the input side is ready again
// once the final result of a transaction has gone into the output register. No clearing
// is needed after reset, as the armed bits live in flip-flops.
module timer_min_heap_scheduler_unit #(
  parameter int MAX_TIMERS = tmhs_pkg::MAX_TIMERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: handle, deadline, period, tag, now, budget, zero fill.
  input  logic [tmhs_pkg::IN_DATA_W-1:0]   in_tdata,
  // Fields from bit 0: opcode.
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: status, fired_handle, fired_tag, armed_count, head_deadline, zero fill.
  output logic [tmhs_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Fields from bit 0: fired.
  output logic                             out_tuser,
  output logic                             out_tlast
);

  localparam int CAP    = (MAX_TIMERS < tmhs_pkg::NUM_HANDLES) ? MAX_TIMERS
                                                               : tmhs_pkg::NUM_HANDLES;
  localparam int SLOT_W = $clog2(CAP);
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int IW     = SLOT_W + 2;
  localparam int HW     = tmhs_pkg::HANDLE_W;
  localparam int TW     = tmhs_pkg::TIME_W;
  localparam int GW     = tmhs_pkg::TAG_W;
  localparam int BW     = tmhs_pkg::BUDGET_W;
  localparam int ENT_W  = HW + TW;
  localparam int TM_W   = TW + GW;
  localparam int OUT_DATA_W_L = tmhs_pkg::OUT_DATA_W;

  logic [HW-1:0] in_handle;
  logic [TW-1:0] in_deadline, in_period, in_now;
  logic [GW-1:0] in_tag;
  logic [BW-1:0] in_budget, bud_c;

  assign in_handle   = in_tdata[5:0];
  assign in_deadline = in_tdata[69:6];
  assign in_period   = in_tdata[133:70];
  assign in_tag      = in_tdata[165:134];
  assign in_now      = in_tdata[229:166];
  assign in_budget   = in_tdata[236:230];
  assign bud_c       = (in_budget > BW'(tmhs_pkg::BUDGET_MAX)) ? BW'(tmhs_pkg::BUDGET_MAX)
                                                               : in_budget;

  tmhs_pkg::state_t    state_r, state_nxt;
  tmhs_pkg::opcode_t   op_r, op_nxt;
  logic [HW-1:0]       h_r, h_nxt;
  logic [TW-1:0]       dl_r, dl_nxt, per_in_r, per_in_nxt, now_r, now_nxt;
  logic [GW-1:0]       tag_in_r, tag_in_nxt;
  logic [BW-1:0]       bud_r, bud_nxt, n_r, n_nxt;
  logic [CNT_W-1:0]    size_r, size_nxt;
  logic [tmhs_pkg::NUM_HANDLES-1:0] armed_r, armed_nxt;
  logic [TW-1:0]       head_d_r;
  logic [HW-1:0]       head_h_r;
  logic [SLOT_W-1:0]   i_r, i_nxt;
  tmhs_pkg::heap_ent_t el_r, el_nxt, cl_r, cl_nxt;
  logic                up_after_r, up_after_nxt, moved_r, moved_nxt;
  logic                arm_pend_r, arm_pend_nxt;
  logic                status_r, status_nxt, fired_r, fired_nxt;
  logic [HW-1:0]       fh_r, fh_nxt;
  logic [GW-1:0]       ftag_r, ftag_nxt;
  logic [TW-1:0]       per_r, per_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt, out_fired_r, out_fired_nxt;
  logic [OUT_DATA_W_L-1:0] out_data_r, out_data_nxt;

  logic                heap_we;
  logic [SLOT_W-1:0]   heap_waddr, heap_raddr;
  tmhs_pkg::heap_ent_t heap_wdata, heap_rdata;
  logic                pos_we;
  logic [HW-1:0]       pos_waddr;
  logic [SLOT_W-1:0]   pos_wdata, pos_rdata;
  logic                tm_we;
  logic [TM_W-1:0]     tm_rdata;
  logic                div_start, div_busy, div_done;
  logic [TW-1:0]       div_rem;

  logic [IW-1:0]       lx, rx, szx;
  logic [SLOT_W-1:0]   par;
  logic [CNT_W-1:0]    size_dec;
  logic                lwin, rwin, more;
  logic [TW-1:0]       best_d;
  logic                in_acc, out_free;

  tmhs_ram #(.WIDTH(ENT_W), .DEPTH(CAP)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  tmhs_ram #(.WIDTH(SLOT_W), .DEPTH(tmhs_pkg::NUM_HANDLES)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(in_handle), .rdata(pos_rdata)
  );

  tmhs_ram #(.WIDTH(TM_W), .DEPTH(tmhs_pkg::NUM_HANDLES)) u_timer (
    .clk(clk), .we(tm_we), .waddr(h_r), .wdata({per_in_r, tag_in_r}),
    .raddr(head_h_r), .rdata(tm_rdata)
  );

  tmhs_rem_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(now_r - head_d_r),
    .divisor(per_r), .busy(div_busy), .done(div_done), .rem(div_rem)
  );

  assign in_tready = (state_r == tmhs_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign lx       = IW'({i_r, 1'b1});
  assign rx       = lx + IW'(1);
  assign szx      = IW'(size_r);
  assign par      = SLOT_W'((i_r - SLOT_W'(1)) >> 1);
  assign size_dec = size_r - CNT_W'(1);
  assign lwin     = cl_r.d < el_r.d;
  assign best_d   = lwin ? cl_r.d : el_r.d;
  assign rwin     = heap_rdata.d < best_d;
  assign more     = (size_r != '0) && (head_d_r <= now_r) && ((n_r + BW'(1)) < bud_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    h_nxt         = h_r;
    dl_nxt        = dl_r;
    per_in_nxt    = per_in_r;
    tag_in_nxt    = tag_in_r;
    now_nxt       = now_r;
    bud_nxt       = bud_r;
    n_nxt         = n_r;
    size_nxt      = size_r;
    armed_nxt     = armed_r;
    i_nxt         = i_r;
    el_nxt        = el_r;
    cl_nxt        = cl_r;
    up_after_nxt  = up_after_r;
    moved_nxt     = moved_r;
    arm_pend_nxt  = arm_pend_r;
    status_nxt    = status_r;
    fired_nxt     = fired_r;
    fh_nxt        = fh_r;
    ftag_nxt      = ftag_r;
    per_nxt       = per_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_fired_nxt = out_fired_r;
    out_data_nxt  = out_data_r;
    heap_we       = 1'b0;
    heap_waddr    = i_r;
    heap_wdata    = el_r;
    heap_raddr    = '0;
    pos_we        = 1'b0;
    pos_waddr     = el_r.h;
    pos_wdata     = i_r;
    tm_we         = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      tmhs_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt       = tmhs_pkg::opcode_t'(in_tuser);
          h_nxt        = in_handle;
          dl_nxt       = in_deadline;
          per_in_nxt   = in_period;
          tag_in_nxt   = in_tag;
          now_nxt      = in_now;
          bud_nxt      = bud_c;
          n_nxt        = '0;
          status_nxt   = 1'b0;
          fired_nxt    = 1'b0;
          arm_pend_nxt = 1'b0;
          state_nxt    = tmhs_pkg::ST_EMIT;
          unique case (tmhs_pkg::opcode_t'(in_tuser))
            tmhs_pkg::OP_SET: begin
              if (armed_r[in_handle]) begin
                arm_pend_nxt = 1'b1;
                state_nxt    = tmhs_pkg::ST_DIS_POS;
              end else if (size_r == CNT_W'(CAP)) begin
                status_nxt = 1'b1;
              end else begin
                state_nxt = tmhs_pkg::ST_ARM;
              end
            end
            tmhs_pkg::OP_REMOVE: begin
              if (armed_r[in_handle]) begin
                state_nxt = tmhs_pkg::ST_DIS_POS;
              end
            end
            tmhs_pkg::OP_EXPIRE: begin
              if ((size_r != '0) && (head_d_r <= in_now) && (bud_c != '0)) begin
                state_nxt = tmhs_pkg::ST_EXP_CHK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tmhs_pkg::ST_DIS_POS: begin
        armed_nxt[h_r] = 1'b0;
        size_nxt       = size_dec;
        i_nxt          = pos_rdata;
        if (CNT_W'(pos_rdata) >= size_dec) begin
          arm_pend_nxt = 1'b0;
          state_nxt    = arm_pend_r ? tmhs_pkg::ST_ARM : tmhs_pkg::ST_EMIT;
        end else begin
          heap_raddr = SLOT_W'(size_dec);
          state_nxt  = tmhs_pkg::ST_DIS_LAST;
        end
      end
      tmhs_pkg::ST_DIS_LAST: begin
        el_nxt       = heap_rdata;
        up_after_nxt = 1'b1;
        moved_nxt    = 1'b0;
        state_nxt    = tmhs_pkg::ST_SD_START;
      end
      tmhs_pkg::ST_ARM: begin
        tm_we          = 1'b1;
        el_nxt.h       = h_r;
        el_nxt.d       = dl_r;
        i_nxt          = SLOT_W'(size_r);
        size_nxt       = size_r + CNT_W'(1);
        armed_nxt[h_r] = 1'b1;
        state_nxt      = tmhs_pkg::ST_SU_START;
      end
      tmhs_pkg::ST_SD_START: begin
        if (lx >= szx) begin
          if (up_after_r && !moved_r) begin
            up_after_nxt = 1'b0;
            state_nxt    = tmhs_pkg::ST_SU_START;
          end else begin
            heap_we      = 1'b1;
            pos_we       = 1'b1;
            arm_pend_nxt = 1'b0;
            state_nxt    = arm_pend_r ? tmhs_pkg::ST_ARM : tmhs_pkg::ST_EMIT;
          end
        end else begin
          heap_raddr = lx[SLOT_W-1:0];
          state_nxt  = tmhs_pkg::ST_SD_L;
        end
      end
      tmhs_pkg::ST_SD_L: begin
        cl_nxt = heap_rdata;
        if (rx < szx) begin
          heap_raddr = rx[SLOT_W-1:0];
          state_nxt  = tmhs_pkg::ST_SD_R;
        end else if (heap_rdata.d < el_r.d) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.h;
          i_nxt      = lx[SLOT_W-1:0];
          moved_nxt  = 1'b1;
          state_nxt  = tmhs_pkg::ST_SD_START;
        end else if (up_after_r && !moved_r) begin
          up_after_nxt = 1'b0;
          state_nxt    = tmhs_pkg::ST_SU_START;
        end else begin
          heap_we      = 1'b1;
          pos_we       = 1'b1;
          arm_pend_nxt = 1'b0;
          state_nxt    = arm_pend_r ? tmhs_pkg::ST_ARM : tmhs_pkg::ST_EMIT;
        end
      end
      tmhs_pkg::ST_SD_R: begin
        if (rwin) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.h;
          i_nxt      = rx[SLOT_W-1:0];
          moved_nxt  = 1'b1;
          state_nxt  = tmhs_pkg::ST_SD_START;
        end else if (lwin) begin
          heap_we    = 1'b1;
          heap_wdata = cl_r;
          pos_we     = 1'b1;
          pos_waddr  = cl_r.h;
          i_nxt      = lx[SLOT_W-1:0];
          moved_nxt  = 1'b1;
          state_nxt  = tmhs_pkg::ST_SD_START;
        end else if (up_after_r && !moved_r) begin
          up_after_nxt = 1'b0;
          state_nxt    = tmhs_pkg::ST_SU_START;
        end else begin
          heap_we      = 1'b1;
          pos_we       = 1'b1;
          arm_pend_nxt = 1'b0;
          state_nxt    = arm_pend_r ? tmhs_pkg::ST_ARM : tmhs_pkg::ST_EMIT;
        end
      end
      tmhs_pkg::ST_SU_START: begin
        if (i_r == '0) begin
          heap_we      = 1'b1;
          pos_we       = 1'b1;
          arm_pend_nxt = 1'b0;
          state_nxt    = arm_pend_r ? tmhs_pkg::ST_ARM : tmhs_pkg::ST_EMIT;
        end else begin
          heap_raddr = par;
          state_nxt  = tmhs_pkg::ST_SU_P;
        end
      end
      tmhs_pkg::ST_SU_P: begin
        if (heap_rdata.d <= el_r.d) begin
          heap_we      = 1'b1;
          pos_we       = 1'b1;
          arm_pend_nxt = 1'b0;
          state_nxt    = arm_pend_r ? tmhs_pkg::ST_ARM : tmhs_pkg::ST_EMIT;
        end else begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = heap_rdata.h;
          i_nxt      = par;
          state_nxt  = tmhs_pkg::ST_SU_START;
        end
      end
      tmhs_pkg::ST_EXP_CHK: begin
        state_nxt = tmhs_pkg::ST_EXP_TM;
      end
      tmhs_pkg::ST_EXP_TM: begin
        fired_nxt = 1'b1;
        fh_nxt    = head_h_r;
        ftag_nxt  = tm_rdata[GW-1:0];
        per_nxt   = tm_rdata[TM_W-1:GW];
        if (tm_rdata[TM_W-1:GW] != '0) begin
          state_nxt = tmhs_pkg::ST_EXP_DIV;
        end else begin
          armed_nxt[head_h_r] = 1'b0;
          size_nxt            = size_dec;
          i_nxt               = '0;
          if (size_dec == '0) begin
            state_nxt = tmhs_pkg::ST_EMIT;
          end else begin
            heap_raddr = SLOT_W'(size_dec);
            state_nxt  = tmhs_pkg::ST_DIS_LAST;
          end
        end
      end
      tmhs_pkg::ST_EXP_DIV: begin
        if (!div_busy && !div_done) begin
          div_start = 1'b1;
        end
        if (div_done) begin
          el_nxt.h     = head_h_r;
          el_nxt.d     = now_r - div_rem + per_r;
          i_nxt        = '0;
          up_after_nxt = 1'b0;
          moved_nxt    = 1'b0;
          state_nxt    = tmhs_pkg::ST_SD_START;
        end
      end
      tmhs_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = fired_r;
          out_last_nxt  = !(fired_r && more);
          out_data_nxt  = {2'b00,
                           (size_r != '0) ? head_d_r : {TW{1'b0}},
                           7'(size_r),
                           fired_r ? ftag_r : {GW{1'b0}},
                           fired_r ? fh_r : {HW{1'b0}},
                           status_r};
          if (fired_r && more) begin
            n_nxt     = n_r + BW'(1);
            state_nxt = tmhs_pkg::ST_EXP_CHK;
          end else begin
            state_nxt = tmhs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tmhs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmhs_pkg::ST_IDLE;
      size_r      <= '0;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
      arm_pend_r  <= 1'b0;
      up_after_r  <= 1'b0;
      moved_r     <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
      arm_pend_r  <= arm_pend_nxt;
      up_after_r  <= up_after_nxt;
      moved_r     <= moved_nxt;
      n_r         <= n_nxt;
    end
    op_r        <= op_nxt;
    h_r         <= h_nxt;
    dl_r        <= dl_nxt;
    per_in_r    <= per_in_nxt;
    tag_in_r    <= tag_in_nxt;
    now_r       <= now_nxt;
    bud_r       <= bud_nxt;
    i_r         <= i_nxt;
    el_r        <= el_nxt;
    cl_r        <= cl_nxt;
    status_r    <= status_nxt;
    fired_r     <= fired_nxt;
    fh_r        <= fh_nxt;
    ftag_r      <= ftag_nxt;
    per_r       <= per_nxt;
    out_last_r  <= out_last_nxt;
    out_fired_r <= out_fired_nxt;
    out_data_r  <= out_data_nxt;
    if (heap_we && (heap_waddr == '0)) begin
      head_d_r <= heap_wdata.d;
      head_h_r <= heap_wdata.h;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;

  // The armed bits and the heap size must always agree.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(armed_r) == int'(size_r))
    else $error("armed bits disagree with heap size");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CNT_W'(CAP))
    else $error("heap size above capacity");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_busy)
    else $error("divider busy while idle");

  a_opcode_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmhs_pkg::ST_EXP_TM) |-> (op_r == tmhs_pkg::OP_EXPIRE))
    else $error("timer read outside an expire transaction");

endmodule

// File: sim/testbench.sv
// Self-checking testbench of the timer heap scheduler, driven by directed and random transactions.
`timescale 1ns / 1ps
module testbench;

  localparam int HEAP_CAP = (tmhs_pkg::MAX_TIMERS_DEF < tmhs_pkg::NUM_HANDLES)
                            ? tmhs_pkg::MAX_TIMERS_DEF : tmhs_pkg::NUM_HANDLES;

  typedef struct packed {
    logic                          status;
    logic                          fired;
    logic [tmhs_pkg::HANDLE_W-1:0] fired_handle;
    logic [tmhs_pkg::TAG_W-1:0]    fired_tag;
    logic                          last;
    logic [tmhs_pkg::COUNT_W-1:0]  armed_count;
    logic [tmhs_pkg::TIME_W-1:0]   head_deadline;
  } timer_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tmhs_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tmhs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  timer_min_heap_scheduler_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #10 clk = ~clk;

  // Shadow copy of the timer heap.
  logic [tmhs_pkg::HANDLE_W-1:0] slot_handle [tmhs_pkg::NUM_HANDLES];
  int unsigned                   handle_slot [tmhs_pkg::NUM_HANDLES];
  bit                            handle_armed [tmhs_pkg::NUM_HANDLES];
  logic [tmhs_pkg::TIME_W-1:0]   tm_deadline [tmhs_pkg::NUM_HANDLES];
  logic [tmhs_pkg::TIME_W-1:0]   tm_period [tmhs_pkg::NUM_HANDLES];
  logic [tmhs_pkg::TAG_W-1:0]    tm_tag [tmhs_pkg::NUM_HANDLES];
  int unsigned                   armed_total;
  timer_event_t                  pending_events [$];
  int                            failures = 0;
  logic [tmhs_pkg::TIME_W-1:0]   clock_now = 64'd1000;

  function automatic logic [tmhs_pkg::TIME_W-1:0] slot_deadline(int unsigned s);
    return tm_deadline[slot_handle[s]];
  endfunction

  function automatic void put_slot(int unsigned s, logic [tmhs_pkg::HANDLE_W-1:0] h);
    slot_handle[s] = h;
    handle_slot[h] = s;
  endfunction

  function automatic void raise_slot(int unsigned i);
    logic [tmhs_pkg::HANDLE_W-1:0] h;
    int unsigned p;
    h = slot_handle[i];
    while (i > 0) begin
      p = (i - 1) / 2;
      if (slot_deadline(p) <= tm_deadline[h]) break;
      put_slot(i, slot_handle[p]);
      i = p;
    end
    put_slot(i, h);
  endfunction

  function automatic void lower_slot(int unsigned i);
    logic [tmhs_pkg::HANDLE_W-1:0] h;
    int unsigned l, r, s;
    logic [tmhs_pkg::TIME_W-1:0] best;
    h = slot_handle[i];
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      s = i;
      best = tm_deadline[h];
      if (l < armed_total && slot_deadline(l) < best) begin
        s = l;
        best = slot_deadline(l);
      end
      if (r < armed_total && slot_deadline(r) < best) s = r;
      if (s == i) break;
      put_slot(i, slot_handle[s]);
      i = s;
    end
    put_slot(i, h);
  endfunction

  function automatic void disarm_timer(logic [tmhs_pkg::HANDLE_W-1:0] h);
    int unsigned i;
    if (!handle_armed[h] || armed_total == 0) return;
    i = handle_slot[h];
    handle_armed[h] = 1'b0;
    handle_slot[h] = 0;
    armed_total--;
    if (i >= armed_total) return;
    put_slot(i, slot_handle[armed_total]);
    lower_slot(i);
    raise_slot(i);
  endfunction

  function automatic void push_event(logic status, logic fired,
                                     logic [tmhs_pkg::HANDLE_W-1:0] h,
                                     logic [tmhs_pkg::TAG_W-1:0] tag, logic last);
    timer_event_t e;
    e.status = status;
    e.fired = fired;
    e.fired_handle = h;
    e.fired_tag = tag;
    e.last = last;
    e.armed_count = armed_total[tmhs_pkg::COUNT_W-1:0];
    e.head_deadline = armed_total ? slot_deadline(0) : '0;
    pending_events.push_back(e);
  endfunction

  function automatic void predict_timers(tmhs_pkg::opcode_t op,
                                         logic [tmhs_pkg::HANDLE_W-1:0] h,
                                         logic [tmhs_pkg::TIME_W-1:0] dl,
                                         logic [tmhs_pkg::TIME_W-1:0] per,
                                         logic [tmhs_pkg::TAG_W-1:0] tag,
                                         logic [tmhs_pkg::TIME_W-1:0] now,
                                         logic [tmhs_pkg::BUDGET_W-1:0] budget);
    int unsigned n, lim;
    logic [tmhs_pkg::HANDLE_W-1:0] t;
    logic [tmhs_pkg::TIME_W-1:0] k;
    n = 0;
    case (op)
      tmhs_pkg::OP_SET: begin
        if (!handle_armed[h] && armed_total >= HEAP_CAP) begin
          push_event(1'b1, 1'b0, '0, '0, 1'b1);
        end else begin
          disarm_timer(h);
          tm_deadline[h] = dl;
          tm_period[h] = per;
          tm_tag[h] = tag;
          handle_armed[h] = 1'b1;
          put_slot(armed_total, h);
          armed_total++;
          raise_slot(armed_total - 1);
          push_event(1'b0, 1'b0, '0, '0, 1'b1);
        end
      end
      tmhs_pkg::OP_REMOVE: begin
        disarm_timer(h);
        push_event(1'b0, 1'b0, '0, '0, 1'b1);
      end
      tmhs_pkg::OP_NOP: push_event(1'b0, 1'b0, '0, '0, 1'b1);
      default: begin
        lim = (budget > tmhs_pkg::BUDGET_MAX) ? tmhs_pkg::BUDGET_MAX : budget;
        while (armed_total > 0 && slot_deadline(0) <= now && n < lim) begin
          t = slot_handle[0];
          if (tm_period[t] != 0) begin
            k = (now - tm_deadline[t]) / tm_period[t] + 64'd1;
            tm_deadline[t] = tm_deadline[t] + k * tm_period[t];
            lower_slot(0);
          end else begin
            disarm_timer(t);
          end
          push_event(1'b0, 1'b1, t, tm_tag[t], 1'b0);
          n++;
        end
        if (n == 0) push_event(1'b0, 1'b0, '0, '0, 1'b1);
        else pending_events[$].last = 1'b1;
      end
    endcase
  endfunction

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(negedge clk);
  endtask

  task automatic send_timer_op(tmhs_pkg::opcode_t op, logic [tmhs_pkg::HANDLE_W-1:0] h,
                               logic [tmhs_pkg::TIME_W-1:0] dl,
                               logic [tmhs_pkg::TIME_W-1:0] per,
                               logic [tmhs_pkg::TAG_W-1:0] tag,
                               logic [tmhs_pkg::TIME_W-1:0] now,
                               logic [tmhs_pkg::BUDGET_W-1:0] budget);
    idle_gap();
    @(negedge clk);
    in_tdata <= {3'b000, budget, now, tag, per, dl, h};
    in_tuser <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_timers(op, h, dl, per, tag, now, budget);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic set_timer(logic [tmhs_pkg::HANDLE_W-1:0] h, logic [tmhs_pkg::TIME_W-1:0] dl,
                           logic [tmhs_pkg::TIME_W-1:0] per);
    send_timer_op(tmhs_pkg::OP_SET, h, dl, per, $urandom, {$urandom, $urandom},
                  7'($urandom_range(0, 127)));
  endtask

  task automatic expire_timers(logic [tmhs_pkg::TIME_W-1:0] now,
                               logic [tmhs_pkg::BUDGET_W-1:0] budget);
    send_timer_op(tmhs_pkg::OP_EXPIRE, 6'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, $urandom, now, budget);
  endtask

  always @(posedge clk) begin
    timer_event_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[0];
      got.fired_handle = out_tdata[6:1];
      got.fired_tag = out_tdata[38:7];
      got.armed_count = out_tdata[45:39];
      got.head_deadline = out_tdata[109:46];
      got.fired = out_tuser;
      got.last = out_tlast;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failures++;
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
          failures++;
        end
      end
    end
  end

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) out_tready <= 1'b0;
    else if (r < 25) out_tready <= ($urandom_range(0, 1) == 1);
    else out_tready <= 1'b1;
  end

  task automatic test_extremes();
    set_timer(6'd0, 64'd0, 64'd0);
    set_timer(6'd63, '1, '1);
    send_timer_op(tmhs_pkg::OP_NOP, 6'd5, '0, '0, '1, '0, 7'd1);
    send_timer_op(tmhs_pkg::OP_REMOVE, 6'd40, '0, '0, '0, '0, 7'd0);
    expire_timers('1, 7'd0);
    expire_timers(64'd0, 7'd127);
    set_timer(6'd1, 64'd50, 64'd10);
    set_timer(6'd2, 64'd50, 64'd0);
    set_timer(6'd1, 64'd60, 64'd7);
    send_timer_op(tmhs_pkg::OP_REMOVE, 6'd2, '0, '0, '0, '0, 7'd0);
    expire_timers(64'd100, 7'd1);
    expire_timers('1, 7'd3);
    // A huge period wraps the advance back onto the same deadline.
    set_timer(6'd3, 64'd0, 64'h8000_0000_0000_0000);
    expire_timers('1, 7'd4);
    send_timer_op(tmhs_pkg::OP_REMOVE, 6'd63, '0, '0, '0, '0, 7'd0);
    send_timer_op(tmhs_pkg::OP_REMOVE, 6'd3, '0, '0, '0, '0, 7'd0);
    send_timer_op(tmhs_pkg::OP_REMOVE, 6'd1, '0, '0, '0, '0, 7'd0);
  endtask

  task automatic test_full_heap();
    for (int i = 0; i < tmhs_pkg::NUM_HANDLES; i++) begin
      set_timer(6'(i), 64'($urandom_range(0, 5000)), 64'd0);
    end
    set_timer(6'd9, 64'd7, 64'd0);
    expire_timers(64'd10000, 7'd64);
    for (int i = 0; i < tmhs_pkg::NUM_HANDLES; i++) set_timer(6'(i), 64'd5000, 64'd0);
    expire_timers(64'd6000, 7'd64);
  endtask

  task automatic test_random_ops();
    int r;
    logic [tmhs_pkg::TIME_W-1:0] per;
    for (int i = 0; i < 62; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        per = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(1, 300));
        if ($urandom_range(0, 19) == 0) per = {$urandom, $urandom};
        set_timer(6'($urandom_range(0, 20)), clock_now + 64'($urandom_range(0, 400)), per);
      end else if (r < 65) begin
        send_timer_op(tmhs_pkg::OP_REMOVE, 6'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom, {$urandom, $urandom}, 7'($urandom));
      end else if (r < 95) begin
        clock_now += 64'($urandom_range(0, 150));
        expire_timers(clock_now, 7'($urandom_range(0, 8)));
      end else if (r < 98) begin
        send_timer_op(tmhs_pkg::OP_NOP, 6'($urandom), {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom, {$urandom, $urandom}, 7'($urandom));
      end else begin
        set_timer(6'($urandom_range(0, 63)), {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_full_heap();
    test_random_ops();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0 && pending_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
